// File: hdl/spq_pkg.sv
`timescale 1ns / 1ps

package spq_pkg;

    // default sizes handed to the top level
    localparam int DEPTH_DEFAULT      = 16;
    localparam int VALUE_BITS_DEFAULT = 32;

    // request codes on the input channel
    typedef enum logic {
        REQ_INSERT = 1'b0,
        REQ_REMOVE = 1'b1
    } req_type_t;

    // per-transaction command broadcast to every cell
    typedef struct packed {
        logic insert;
        logic remove;
    } cell_ctrl_t;

endpackage

// File: hdl/spq_cell.sv
`timescale 1ns / 1ps

module spq_cell #(
    parameter int VALUE_BITS = spq_pkg::VALUE_BITS_DEFAULT
) (
    input  logic                         aclk,
    input  spq_pkg::cell_ctrl_t          ctrl,
    input  logic                         occupied,
    input  logic signed [VALUE_BITS-1:0] new_value,
    input  logic signed [VALUE_BITS-1:0] left_value,
    input  logic                         left_lt,
    input  logic signed [VALUE_BITS-1:0] right_value,
    output logic signed [VALUE_BITS-1:0] value,
    output logic signed [VALUE_BITS-1:0] value_next,
    output logic                         lt
);

    logic signed [VALUE_BITS-1:0] value_reg;

    // stored entry is occupied and strictly below the incoming value
    assign lt = occupied && (value_reg < new_value);

    // keep, take the new value, shift in from the left, or shift in from the right
    always_comb begin
        value_next = value_reg;
        if (ctrl.insert) begin
            if (!lt) begin
                value_next = left_lt ? new_value : left_value;
            end
        end else if (ctrl.remove) begin
            value_next = right_value;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

// File: hdl/sorted_priority_queue_unit.sv
`timescale 1ns / 1ps
// Sorted priority queue built as a chain of compare-and-shift cells.
// Input channel (s_valid/s_ready): s_req_type selects insert of s_item_value
// or removal of the smallest stored value. Every transaction yields exactly one
// result transaction on the output channel (m_valid/m_ready) carrying the
// smallest and largest stored values (0 when empty), the count, empty and full
// flags, and a refused flag for an insert while full or a remove while empty.
// Equal values: a newly inserted value goes ahead of stored equal values.
// The result is registered in the output register, or in the skid register while
// the output register holds an untaken result. Throughput: one request per cycle
// while s_ready is high; every cell compares against the incoming value and shifts
// toward its neighbor in the same cycle, so a request always completes in a single update of the chain.
// A two-entry output stage (output register plus skid register) lets one more
// request be taken while a result waits; s_ready drops only when both are full,
// that is when m_ready stays low for two results.
// Reset (aresetn low, synchronous) empties the queue and drops pending results;
// stored entries are not cleared, only entries below the count are ever read.
module sorted_priority_queue_unit #(
    parameter int DEPTH      = spq_pkg::DEPTH_DEFAULT,
    parameter int VALUE_BITS = spq_pkg::VALUE_BITS_DEFAULT,
    parameter int COUNT_BITS = $clog2(DEPTH + 1)
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_req_type,
    input  logic signed [VALUE_BITS-1:0] s_item_value,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [VALUE_BITS-1:0] m_head_value,
    output logic signed [VALUE_BITS-1:0] m_tail_value,
    output logic        [COUNT_BITS-1:0] m_entry_count,
    output logic                         m_is_empty,
    output logic                         m_is_full,
    output logic                         m_request_refused
);

    typedef struct packed {
        logic signed [VALUE_BITS-1:0] head;
        logic signed [VALUE_BITS-1:0] tail;
        logic        [COUNT_BITS-1:0] count;
        logic                         empty;
        logic                         full;
        logic                         refused;
    } result_t;

    localparam logic [COUNT_BITS-1:0] FULL_COUNT = COUNT_BITS'(DEPTH);

    logic [COUNT_BITS-1:0]        count_reg, count_next;
    logic signed [VALUE_BITS-1:0] tail_reg, tail_next;
    logic                         out_valid_reg, skid_valid_reg;
    result_t                      out_reg, skid_reg, result_next;
    logic                         accept, take, is_full, is_empty, refused;
    spq_pkg::cell_ctrl_t          ctrl;

    logic signed [VALUE_BITS-1:0] vals_ext [0:DEPTH+1];
    logic signed [VALUE_BITS-1:0] cell_next [0:DEPTH-1];
    logic                         lt_chain [0:DEPTH];

    // request decode
    assign s_ready  = !skid_valid_reg;
    assign accept   = s_valid && s_ready;
    assign take     = out_valid_reg && m_ready;
    assign is_full  = (count_reg == FULL_COUNT);
    assign is_empty = (count_reg == '0);

    always_comb begin
        ctrl.insert = accept && (s_req_type == spq_pkg::REQ_INSERT) && !is_full;
        ctrl.remove = accept && (s_req_type == spq_pkg::REQ_REMOVE) && !is_empty;
        refused     = (s_req_type == spq_pkg::REQ_INSERT) ? is_full : is_empty;
    end

    // chain of cells with zero padding at both ends
    assign vals_ext[0]       = '0;
    assign vals_ext[DEPTH+1] = '0;
    assign lt_chain[0]       = 1'b1;

    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        logic occupied;
        assign occupied = (count_reg > COUNT_BITS'(gi));

        spq_cell #(
            .VALUE_BITS(VALUE_BITS)
        ) u_cell (
            .aclk       (aclk),
            .ctrl       (ctrl),
            .occupied   (occupied),
            .new_value  (s_item_value),
            .left_value (vals_ext[gi]),
            .left_lt    (lt_chain[gi]),
            .right_value(vals_ext[gi+2]),
            .value      (vals_ext[gi+1]),
            .value_next (cell_next[gi]),
            .lt         (lt_chain[gi+1])
        );
    end

    // count and largest value tracking
    always_comb begin
        count_next = count_reg;
        tail_next  = tail_reg;
        if (ctrl.insert) begin
            count_next = count_reg + COUNT_BITS'(1);
            if (is_empty || (s_item_value > tail_reg)) begin
                tail_next = s_item_value;
            end
        end else if (ctrl.remove) begin
            count_next = count_reg - COUNT_BITS'(1);
            if (count_reg == COUNT_BITS'(1)) begin
                tail_next = '0;
            end
        end
    end

    // result of the current transaction
    always_comb begin
        result_next.count   = count_next;
        result_next.empty   = (count_next == '0);
        result_next.full    = (count_next == FULL_COUNT);
        result_next.head    = (count_next == '0) ? '0 : cell_next[0];
        result_next.tail    = (count_next == '0) ? '0 : tail_next;
        result_next.refused = refused;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            tail_reg <= tail_next;
        end
    end

    // output register with skid stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || take) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= accept;
            end
        end else if (accept) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || take) begin
            out_reg <= skid_valid_reg ? skid_reg : result_next;
        end else if (accept) begin
            skid_reg <= result_next;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_head_value      = out_reg.head;
    assign m_tail_value      = out_reg.tail;
    assign m_entry_count     = out_reg.count;
    assign m_is_empty        = out_reg.empty;
    assign m_is_full         = out_reg.full;
    assign m_request_refused = out_reg.refused;

    // checks
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FULL_COUNT)
        else $error("entry count beyond depth");

    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a result while output register is empty");

    a_refused_keeps_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && refused) |=> (count_reg == $past(count_reg)))
        else $error("refused request changed the count");

    a_front_sorted: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg >= COUNT_BITS'(2)) |-> (vals_ext[1] <= vals_ext[2]))
        else $error("front cells out of order");

    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_reg.empty) |-> (out_reg.head == '0 && out_reg.tail == '0))
        else $error("empty result with nonzero head or tail");

endmodule
